FILE: rtl/sli_pkg.sv
package sli_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;
   localparam int RSP_DATA_W = 40;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic insert;
      logic delete;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic found;
   } dp_stat_type;

endpackage

FILE: rtl/sorted_list_insert_delete_top.sv
// Sorted list of signed 32-bit values, up to DEPTH entries, duplicates allowed.
// Request channel (req_): tuser carries the command (insert, delete, read out),
// tdata the signed value. Response channel (rsp_): tdata carries the item value,
// status and occupancy; tlast marks the final word caused by a request.
// Insert and delete are done in the cycle the request is taken: every entry
// register compares against the value at once and the list shifts at the end of that cycle.
// Their single response word is valid the next cycle, so one request per cycle
// is taken while the receiver keeps up.
// A read out emits one word per cycle while the receiver keeps up, in
// ascending order, taken from the entry registers by an index counter, and no
// request is taken until the last word is loaded.
// An empty read out gives one word with status empty.
// The response stage is one register: when the receiver stalls it holds its
// word, and requests or read-out words wait until it is taken.
// Reset empties the list at once; no clearing pass is needed.
module sorted_list_insert_delete_top
   import sli_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // [31:0] value
   input  logic [CMD_W-1:0]      req_tuser,   // [1:0] command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] item_value, [33:32] status,
                                              // [38:34] occupancy, [39] zero
   output logic                  rsp_tlast
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   dp_cmd_type                dp_cmd;
   dp_stat_type               dp_stat;
   logic [IDX_W-1:0]          rd_idx;
   logic signed [VALUE_W-1:0] rd_data;
   logic [CNT_W-1:0]          count;
   logic [VALUE_W-1:0]        rsp_item;
   logic [STAT_W-1:0]         rsp_status;
   logic [OCC_W-1:0]          rsp_occ;

   sli_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item),
      .rsp_status (rsp_status),
      .rsp_occ    (rsp_occ),
      .rsp_last   (rsp_tlast),
      .dp_cmd     (dp_cmd),
      .rd_idx     (rd_idx),
      .rd_data    (rd_data),
      .count      (count),
      .dp_stat    (dp_stat)
   );

   sli_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (dp_cmd),
      .value   ($signed(req_tdata)),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .count   (count),
      .stat    (dp_stat)
   );

   assign rsp_tdata = {1'b0, rsp_occ, rsp_status, rsp_item};

endmodule

FILE: rtl/sli_datapath.sv
module sli_datapath
   import sli_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   input  logic signed [VALUE_W-1:0] value,
   input  logic [IDX_W-1:0]          rd_idx,
   output logic signed [VALUE_W-1:0] rd_data,
   output logic [CNT_W-1:0]          count,
   output dp_stat_type               stat
);

   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [VALUE_W-1:0] ins_in     [DEPTH];
   logic signed [VALUE_W-1:0] del_in     [DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DEPTH-1:0] lt, eq, hit;

   // every cell compares against the request value in parallel
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] < value);
         eq[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] == value);
      end
      hit[0] = eq[0];
      for (int i = 1; i < DEPTH; i++) begin
         hit[i] = hit[i-1] | eq[i];
      end
      // insert: cells below the slot keep, the slot takes value, the rest shift up
      for (int i = 0; i < DEPTH; i++) begin
         if (lt[i]) begin
            ins_in[i] = entries_ff[i];
         end else if (i == 0) begin
            ins_in[i] = value;
         end else if (lt[i-1]) begin
            ins_in[i] = value;
         end else begin
            ins_in[i] = entries_ff[i-1];
         end
      end
      // delete: cells from the first match on take their upper neighbor
      for (int i = 0; i < DEPTH - 1; i++) begin
         del_in[i] = hit[i] ? entries_ff[i+1] : entries_ff[i];
      end
      del_in[DEPTH-1] = entries_ff[DEPTH-1];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.delete && hit[DEPTH-1]) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         entries_ff <= ins_in;
      end else if (cmd.delete && hit[DEPTH-1]) begin
         entries_ff <= del_in;
      end
   end

   assign rd_data    = entries_ff[rd_idx];
   assign count      = count_ff;
   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.found = hit[DEPTH-1];

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !stat.full)
      else $error("insert into full list");

   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      cmd.delete && stat.found |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("delete did not drop count");

endmodule

FILE: rtl/sli_ctrl.sv
module sli_ctrl
   import sli_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [CMD_W-1:0]          req_cmd,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [VALUE_W-1:0]        rsp_item,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [OCC_W-1:0]          rsp_occ,
   output logic                      rsp_last,
   output dp_cmd_type                dp_cmd,
   output logic [IDX_W-1:0]          rd_idx,
   input  logic signed [VALUE_W-1:0] rd_data,
   input  logic [CNT_W-1:0]          count,
   input  dp_stat_type               dp_stat
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] item_ff, item_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic last_ff, last_in;
   logic out_free, accept, load, read_last;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign read_last  = (CNT_W'(idx_ff) + CNT_W'(1)) == count;

   assign dp_cmd.insert = accept && (req_cmd == CMD_INSERT) && !dp_stat.full;
   assign dp_cmd.delete = accept && (req_cmd == CMD_DELETE);
   assign rd_idx        = idx_ff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      load      = 1'b0;
      item_in   = item_ff;
      status_in = status_ff;
      occ_in    = occ_ff;
      last_in   = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               load    = 1'b1;
               item_in = '0;
               last_in = 1'b1;
               unique case (req_cmd)
                  CMD_INSERT: begin
                     status_in = dp_stat.full ? ST_FULL : ST_OK;
                     occ_in    = dp_stat.full ? count : count + CNT_W'(1);
                  end
                  CMD_DELETE: begin
                     status_in = dp_stat.found ? ST_OK : ST_NOTFOUND;
                     occ_in    = dp_stat.found ? count - CNT_W'(1) : count;
                  end
                  CMD_READ: begin
                     status_in = ST_EMPTY;
                     occ_in    = count;
                     if (!dp_stat.empty) begin
                        // words come out of the read state instead
                        load     = 1'b0;
                        idx_in   = '0;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                     occ_in    = count;
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               load      = 1'b1;
               item_in   = rd_data;
               status_in = ST_OK;
               occ_in    = count;
               last_in   = read_last;
               idx_in    = idx_ff + IDX_W'(1);
               if (read_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff   <= item_in;
         status_ff <= status_in;
         occ_ff    <= occ_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_item   = item_ff;
   assign rsp_status = status_ff;
   assign rsp_occ    = OCC_W'(occ_ff);
   assign rsp_last   = last_ff;

   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !req_tready)
      else $error("request taken during read out");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !load)
      else $error("pending response overwritten");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !dp_stat.empty && (CNT_W'(idx_ff) < count))
      else $error("read index beyond list");

endmodule
